@@ sv/rrt_pkg.sv @@
// Shared types and constants for the RRT* tree extension engine.
package rrt_pkg;

  // Field widths
  localparam int CW        = 24;             // coordinate width, signed
  localparam int IDW       = 10;             // node index width
  localparam int MAX_NODES = 1 << IDW;       // tree capacity
  localparam int CNTW      = IDW + 1;        // node count width
  localparam int LIMW      = 23;             // step size and radius width
  localparam int COSTW     = 32;             // path cost width
  localparam int CFGW      = 3;              // config register index width

  // Arithmetic widths
  localparam int MULW  = CW + 1;             // magnitude of a coordinate difference
  localparam int PRODW = 2 * MULW;           // multiplier product
  localparam int SQW   = PRODW + 2;          // sum of three squares
  localparam int RTW   = SQW / 2;            // integer square root
  localparam int SRW   = RTW + 3;            // square root remainder
  localparam int NUMW  = LIMW + MULW + 1;    // steering dividend
  localparam int DRW   = RTW + 1;            // divider remainder
  localparam int SCW   = $clog2(NUMW);       // step counter of the sequencer

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_PROPOSE = 2'd1,
    CMD_COMMIT  = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_PEND   = 3'd1,
    ST_FULL      = 3'd2,
    ST_COLLIDE   = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [CFGW-1:0] {
    REG_STEP    = 3'd0,
    REG_RADIUS  = 3'd1,
    REG_GOAL_X  = 3'd2,
    REG_GOAL_Y  = 3'd3,
    REG_GOAL_Z  = 3'd4,
    REG_START_X = 3'd5,
    REG_START_Y = 3'd6,
    REG_START_Z = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PREP, S_LOAD, S_SQ, S_SQRT, S_SMUL, S_SNUM, S_SDIV, S_SFIN
  } state_t;

  // What the current distance computation is for
  typedef enum logic [2:0] {
    PH_NEAR, PH_STEER, PH_PCOST, PH_CINIT, PH_PASS1, PH_PASS2, PH_GOAL, PH_READ
  } phase_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [IDW-1:0]       parent;
    logic [COSTW-1:0]     cost;
  } node_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [IDW-1:0]       id;
    logic [IDW-1:0]       parent;
    logic [COSTW-1:0]     cost;
    status_t              status;
  } result_t;

endpackage

@@ sv/rrt_star_tree_extension.sv @@
// RRT* tree extension engine: node store, sequencer and shared arithmetic unit.
//
// A command is taken when start is high and busy is low; its result appears for
// one cycle with done high and cannot be held off. Restart, a commit without a
// usable proposal and a read out of range give their result in the cycle after
// acceptance; a valid read first passes the load and distance states. All other
// work runs on one shared multiplier, a two-bit-per-cycle square root unit and a
// one-bit-per-cycle divider, stepping through the node memory (one read and one
// write port) one node at a time: each node visited passes the load and squared
// distance states, plus a square root when its distance needs one. A propose
// over N nodes squares the limits, then searches all N nodes for the nearest; an
// unsteered point then takes a square root for its cost, a steered one is first
// moved per axis through the multiplier and divider and then costed. A commit
// makes two passes over the N existing nodes, with a square root for each node
// inside the search radius in each pass. The result appears as busy drops. After
// reset the block is busy for one cycle while it writes the root.
module rrt_star_tree_extension (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic [1:0]                    cmd,
  input  logic signed [rrt_pkg::CW-1:0] sample_x,
  input  logic signed [rrt_pkg::CW-1:0] sample_y,
  input  logic signed [rrt_pkg::CW-1:0] sample_z,
  input  logic                          collision_free,
  input  logic [rrt_pkg::IDW-1:0]       node_index,
  output logic signed [rrt_pkg::CW-1:0] point_x,
  output logic signed [rrt_pkg::CW-1:0] point_y,
  output logic signed [rrt_pkg::CW-1:0] point_z,
  output logic [rrt_pkg::IDW-1:0]       node_id,
  output logic [rrt_pkg::IDW-1:0]       parent_id,
  output logic [rrt_pkg::COSTW-1:0]     path_cost,
  output logic                          goal_reached,
  output logic [rrt_pkg::IDW-1:0]       goal_node,
  output logic [2:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrt_pkg::CFGW-1:0]      cfg_index,
  input  logic [rrt_pkg::CW-1:0]        cfg_data
);
  import rrt_pkg::*;

  // Saturating cost sum
  function automatic logic [COSTW-1:0] sat_add(input logic [COSTW-1:0] c,
                                               input logic [RTW-1:0] d);
    logic [COSTW:0] s;
    s = {1'b0, c} + (COSTW + 1)'(d);
    return s[COSTW] ? {COSTW{1'b1}} : s[COSTW-1:0];
  endfunction

  // Clamp to the signed coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW+1:0] v);
    logic hi_ok;
    hi_ok = (v[CW+1:CW-1] == 3'b000) || (v[CW+1:CW-1] == 3'b111);
    if (hi_ok) return v[CW-1:0];
    return v[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  // Configuration registers
  logic [LIMW-1:0]      step_len, nbr_radius;
  logic signed [CW-1:0] goal_x, goal_y, goal_z, start_x, start_y, start_z;

  // Sequencer and datapath registers
  state_t               state, state_next;
  phase_t               phase, phase_next;
  logic [SCW-1:0]       cnt, cnt_next;
  logic [1:0]           ax, ax_next;
  logic [CNTW-1:0]      k, k_next;
  logic [CNTW-1:0]      count, count_next;
  logic [IDW-1:0]       best, best_next;
  logic [SQW-1:0]       bd, bd_next;
  logic [SQW-1:0]       acc, acc_next;
  logic [PRODW-1:0]     prod;
  logic [SQW-1:0]       s2, s2_next, r2, r2_next;
  logic signed [CW-1:0] tx, ty, tz, tx_next, ty_next, tz_next;
  logic signed [CW-1:0] nx, ny, nz, nx_next, ny_next, nz_next;
  logic                 pend_valid, pend_valid_next;
  logic signed [CW-1:0] px, py, pz, px_next, py_next, pz_next;
  logic [IDW-1:0]       pn, pn_next;
  logic                 goal_found, goal_found_next;
  logic [IDW-1:0]       goal_index, goal_index_next;
  logic [COSTW-1:0]     cost, cost_next;
  logic [IDW-1:0]       par, par_next;
  logic [SQW-1:0]       sq_v, sq_v_next;
  logic [SRW-1:0]       sq_rem, sq_rem_next;
  logic [RTW-1:0]       sq_root, sq_root_next;
  logic [RTW-1:0]       norm, norm_next;
  logic [NUMW-1:0]      dv_n, dv_n_next;
  logic [DRW-1:0]       dv_rem, dv_rem_next;
  result_t              res, res_next;
  logic                 done_next;

  // Node memory
  node_t                mem [MAX_NODES];
  node_t                rdata;
  logic                 mem_we;
  logic [IDW-1:0]       mem_waddr;
  node_t                mem_wdata;

  // Shared arithmetic
  logic [MULW-1:0]      mul_a, mul_b;
  logic [1:0]           sel;
  logic signed [CW-1:0] t_sel, r_sel;
  logic signed [CW:0]   diff;
  logic [MULW-1:0]      mag;
  logic [SQW-1:0]       sq_now;
  logic [SRW-1:0]       rt_sh, rt_trial;
  logic                 rt_ge;
  logic [RTW-1:0]       rt_fin;
  logic [DRW-1:0]       dv_sh;
  logic                 dv_ge;
  logic                 full;

  assign cfg_ready    = 1'b1;
  assign busy         = (state != S_IDLE);
  assign point_x      = res.x;
  assign point_y      = res.y;
  assign point_z      = res.z;
  assign node_id      = res.id;
  assign parent_id    = res.parent;
  assign path_cost    = res.cost;
  assign status       = res.status;
  assign goal_reached = goal_found;
  assign goal_node    = goal_index;
  assign full         = (count == CNTW'(MAX_NODES));

  // Axis operands: target point against the node just read
  always_comb begin
    sel = (state == S_SQ) ? cnt[1:0] : ax;
    case (sel)
      2'd0:    begin t_sel = tx; r_sel = rdata.x; end
      2'd1:    begin t_sel = ty; r_sel = rdata.y; end
      default: begin t_sel = tz; r_sel = rdata.z; end
    endcase
    diff = {t_sel[CW-1], t_sel} - {r_sel[CW-1], r_sel};
    mag  = diff[CW] ? MULW'(-diff) : MULW'(diff);
  end

  // Square root step: two bits of the radicand per cycle
  assign rt_sh    = {sq_rem[SRW-3:0], sq_v[SQW-1:SQW-2]};
  assign rt_trial = SRW'({sq_root, 2'b01});
  assign rt_ge    = (rt_sh >= rt_trial);
  assign rt_fin   = {sq_root[RTW-2:0], rt_ge};

  // Restoring divider step
  assign dv_sh = {dv_rem[DRW-2:0], dv_n[NUMW-1]};
  assign dv_ge = (dv_sh >= DRW'(norm));

  assign sq_now = acc + SQW'(prod);

  // Sequencer
  always_comb begin
    logic                 advance;
    logic                 start_rt;
    logic [SQW-1:0]       rt_in;
    logic [COSTW-1:0]     c;
    logic [IDW-1:0]       nb;
    logic [SQW-1:0]       nbd;
    logic [CW:0]          off;
    logic signed [CW+1:0] base_w, off_w, steer_w;
    logic signed [CW-1:0] steered;

    advance  = 1'b0;
    start_rt = 1'b0;
    rt_in    = sq_now;
    c        = '0;
    nb       = best;
    nbd      = bd;
    off      = dv_n[CW:0];
    base_w   = {{2{r_sel[CW-1]}}, r_sel};
    off_w    = $signed({1'b0, off});
    steer_w  = (t_sel >= r_sel) ? base_w + off_w : base_w - off_w;
    steered  = sat_coord(steer_w);

    state_next      = state;
    phase_next      = phase;
    cnt_next        = cnt;
    ax_next         = ax;
    k_next          = k;
    count_next      = count;
    best_next       = best;
    bd_next         = bd;
    acc_next        = acc;
    s2_next         = s2;
    r2_next         = r2;
    tx_next         = tx;
    ty_next         = ty;
    tz_next         = tz;
    nx_next         = nx;
    ny_next         = ny;
    nz_next         = nz;
    pend_valid_next = pend_valid;
    px_next         = px;
    py_next         = py;
    pz_next         = pz;
    pn_next         = pn;
    goal_found_next = goal_found;
    goal_index_next = goal_index;
    cost_next       = cost;
    par_next        = par;
    sq_v_next       = sq_v;
    sq_rem_next     = sq_rem;
    sq_root_next    = sq_root;
    norm_next       = norm;
    dv_n_next       = dv_n;
    dv_rem_next     = dv_rem;
    res_next        = res;
    done_next       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '{x: start_x, y: start_y, z: start_z, parent: '0, cost: '0};
    mul_a           = mag;
    mul_b           = mag;

    case (state)
      // Write the root after reset
      S_INIT: begin
        mem_we     = 1'b1;
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_RESTART: begin
              mem_we          = 1'b1;
              count_next      = CNTW'(1);
              pend_valid_next = 1'b0;
              px_next         = '0;
              py_next         = '0;
              pz_next         = '0;
              pn_next         = '0;
              goal_found_next = 1'b0;
              goal_index_next = '0;
              res_next  = '{x: start_x, y: start_y, z: start_z, id: '0, parent: '0,
                            cost: '0, status: ST_OK};
              done_next = 1'b1;
            end
            CMD_PROPOSE: begin
              tx_next    = sample_x;
              ty_next    = sample_y;
              tz_next    = sample_z;
              phase_next = PH_NEAR;
              cnt_next   = '0;
              state_next = S_PREP;
            end
            CMD_COMMIT: begin
              pend_valid_next = 1'b0;
              if (!pend_valid) begin
                res_next  = '{x: '0, y: '0, z: '0, id: '0, parent: '0, cost: '0,
                              status: ST_NO_PEND};
                done_next = 1'b1;
              end else if (full || !collision_free) begin
                res_next  = '{x: px, y: py, z: pz, id: '0, parent: pn, cost: '0,
                              status: full ? ST_FULL : ST_COLLIDE};
                done_next = 1'b1;
              end else begin
                tx_next    = px;
                ty_next    = py;
                tz_next    = pz;
                phase_next = PH_CINIT;
                cnt_next   = '0;
                state_next = S_PREP;
              end
            end
            default: begin
              if ({1'b0, node_index} >= count) begin
                res_next  = '{x: '0, y: '0, z: '0, id: '0, parent: '0, cost: '0,
                              status: ST_BAD_INDEX};
                done_next = 1'b1;
              end else begin
                k_next     = {1'b0, node_index};
                phase_next = PH_READ;
                state_next = S_LOAD;
              end
            end
          endcase
        end
      end

      // Squared step length and radius through the multiplier
      S_PREP: begin
        cnt_next = cnt + 1'b1;
        if (cnt == SCW'(0)) begin
          mul_a = MULW'(step_len);
          mul_b = MULW'(step_len);
        end else if (cnt == SCW'(1)) begin
          s2_next = SQW'(prod);
          mul_a   = MULW'(nbr_radius);
          mul_b   = MULW'(nbr_radius);
        end else begin
          r2_next    = SQW'(prod);
          k_next     = (phase == PH_NEAR) ? '0 : {1'b0, pn};
          state_next = S_LOAD;
        end
      end

      // Memory read latency
      S_LOAD: begin
        cnt_next   = '0;
        state_next = S_SQ;
      end

      // Squared distance, one axis per cycle
      S_SQ: begin
        if (phase == PH_READ) begin
          res_next  = '{x: rdata.x, y: rdata.y, z: rdata.z, id: k[IDW-1:0],
                        parent: rdata.parent, cost: rdata.cost, status: ST_OK};
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (cnt != SCW'(3)) begin
          acc_next = (cnt == SCW'(0)) ? '0 : sq_now;
          cnt_next = cnt + 1'b1;
        end else begin
          acc_next = sq_now;
          case (phase)
            PH_NEAR: begin
              if (k == '0 || sq_now < bd) begin
                nb  = k[IDW-1:0];
                nbd = sq_now;
              end
              best_next = nb;
              bd_next   = nbd;
              if (k + 1'b1 < count) begin
                k_next     = k + 1'b1;
                state_next = S_LOAD;
              end else if (nbd > s2) begin
                k_next     = {1'b0, nb};
                phase_next = PH_STEER;
                start_rt   = 1'b1;
                rt_in      = nbd;
              end else begin
                nx_next    = tx;
                ny_next    = ty;
                nz_next    = tz;
                k_next     = {1'b0, nb};
                phase_next = PH_PCOST;
                state_next = S_LOAD;
              end
            end
            PH_PASS1, PH_PASS2: begin
              if (sq_now < r2) start_rt = 1'b1;
              else advance = 1'b1;
            end
            PH_GOAL: begin
              if (sq_now <= s2) begin
                goal_found_next = 1'b1;
                goal_index_next = k[IDW-1:0];
              end
              res_next  = '{x: px, y: py, z: pz, id: k[IDW-1:0], parent: par,
                            cost: cost, status: ST_OK};
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
            default: start_rt = 1'b1;
          endcase
        end
      end

      S_SQRT: begin
        sq_v_next    = sq_v << 2;
        sq_rem_next  = rt_ge ? rt_sh - rt_trial : rt_sh;
        sq_root_next = rt_fin;
        cnt_next     = cnt + 1'b1;
        if (cnt == SCW'(RTW - 1)) begin
          case (phase)
            PH_STEER: begin
              norm_next  = rt_fin;
              ax_next    = '0;
              state_next = S_SMUL;
            end
            PH_PCOST: begin
              c = sat_add(rdata.cost, rt_fin);
              res_next  = '{x: nx, y: ny, z: nz, id: '0, parent: best, cost: c,
                            status: full ? ST_FULL : ST_OK};
              done_next       = 1'b1;
              pend_valid_next = !full;
              px_next         = nx;
              py_next         = ny;
              pz_next         = nz;
              pn_next         = best;
              state_next      = S_IDLE;
            end
            PH_CINIT: begin
              cost_next  = sat_add(rdata.cost, rt_fin);
              par_next   = pn;
              k_next     = '0;
              phase_next = PH_PASS1;
              state_next = S_LOAD;
            end
            PH_PASS1: begin
              c = sat_add(rdata.cost, rt_fin);
              if (c < cost) begin
                cost_next = c;
                par_next  = k[IDW-1:0];
              end
              advance = 1'b1;
            end
            default: begin
              // Rewire: the new node becomes the parent of a cheaper neighbor
              c = sat_add(cost, rt_fin);
              if (c < rdata.cost) begin
                mem_we    = 1'b1;
                mem_waddr = k[IDW-1:0];
                mem_wdata = '{x: rdata.x, y: rdata.y, z: rdata.z,
                              parent: count[IDW-1:0], cost: c};
              end
              advance = 1'b1;
            end
          endcase
        end
      end

      // Steering: step length * |d| per axis
      S_SMUL: begin
        mul_a      = MULW'(step_len);
        mul_b      = mag;
        state_next = S_SNUM;
      end

      S_SNUM: begin
        dv_n_next   = NUMW'(prod) + NUMW'(norm >> 1);
        dv_rem_next = '0;
        cnt_next    = '0;
        state_next  = S_SDIV;
      end

      S_SDIV: begin
        dv_rem_next = dv_ge ? dv_sh - DRW'(norm) : dv_sh;
        dv_n_next   = {dv_n[NUMW-2:0], dv_ge};
        cnt_next    = cnt + 1'b1;
        if (cnt == SCW'(NUMW - 1)) state_next = S_SFIN;
      end

      S_SFIN: begin
        case (ax)
          2'd0:    nx_next = steered;
          2'd1:    ny_next = steered;
          default: nz_next = steered;
        endcase
        if (ax == 2'd2) begin
          tx_next    = nx_next;
          ty_next    = ny_next;
          tz_next    = nz_next;
          phase_next = PH_PCOST;
          cnt_next   = '0;
          state_next = S_SQ;
        end else begin
          ax_next    = ax + 1'b1;
          state_next = S_SMUL;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Start a square root on the chosen radicand
    if (start_rt) begin
      sq_v_next    = rt_in;
      sq_rem_next  = '0;
      sq_root_next = '0;
      cnt_next     = '0;
      state_next   = S_SQRT;
    end

    // Next node of a commit pass, or the end of the pass
    if (advance) begin
      if (k + 1'b1 < count) begin
        k_next     = k + 1'b1;
        state_next = S_LOAD;
      end else if (phase == PH_PASS1) begin
        mem_we     = 1'b1;
        mem_waddr  = count[IDW-1:0];
        mem_wdata  = '{x: px, y: py, z: pz, parent: par_next, cost: cost_next};
        k_next     = '0;
        phase_next = PH_PASS2;
        state_next = S_LOAD;
      end else begin
        count_next = count + 1'b1;
        k_next     = count;
        tx_next    = goal_x;
        ty_next    = goal_y;
        tz_next    = goal_z;
        phase_next = PH_GOAL;
        state_next = S_LOAD;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= CNTW'(1);
      pend_valid <= 1'b0;
      pn         <= '0;
      goal_found <= 1'b0;
      goal_index <= '0;
      done       <= 1'b0;
    end else begin
      count      <= count_next;
      pend_valid <= pend_valid_next;
      pn         <= pn_next;
      goal_found <= goal_found_next;
      goal_index <= goal_index_next;
      done       <= done_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    phase   <= phase_next;
    cnt     <= cnt_next;
    ax      <= ax_next;
    k       <= k_next;
    best    <= best_next;
    bd      <= bd_next;
    acc     <= acc_next;
    prod    <= mul_a * mul_b;
    s2      <= s2_next;
    r2      <= r2_next;
    tx      <= tx_next;
    ty      <= ty_next;
    tz      <= tz_next;
    nx      <= nx_next;
    ny      <= ny_next;
    nz      <= nz_next;
    px      <= px_next;
    py      <= py_next;
    pz      <= pz_next;
    cost    <= cost_next;
    par     <= par_next;
    sq_v    <= sq_v_next;
    sq_rem  <= sq_rem_next;
    sq_root <= sq_root_next;
    norm    <= norm_next;
    dv_n    <= dv_n_next;
    dv_rem  <= dv_rem_next;
    res     <= res_next;
  end

  // Node memory, registered read at the current node
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[k[IDW-1:0]];
  end

  // Configuration transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      step_len   <= LIMW'(4096);
      nbr_radius <= LIMW'(8192);
      goal_x     <= '0;
      goal_y     <= '0;
      goal_z     <= '0;
      start_x    <= '0;
      start_y    <= '0;
      start_z    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_STEP:    step_len   <= cfg_data[LIMW-1:0];
        REG_RADIUS:  nbr_radius <= cfg_data[LIMW-1:0];
        REG_GOAL_X:  goal_x     <= cfg_data;
        REG_GOAL_Y:  goal_y     <= cfg_data;
        REG_GOAL_Z:  goal_z     <= cfg_data;
        REG_START_X: start_x    <= cfg_data;
        REG_START_Y: start_y    <= cfg_data;
        REG_START_Z: start_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNTW'(MAX_NODES)))
    else $error("node count out of range");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither runs nor answers");

  a_goal_in_tree: assert property (@(posedge clk) disable iff (rst)
    goal_found |-> ({1'b0, goal_index} < count))
    else $error("goal node beyond tree");

  a_pend_in_tree: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ({1'b0, pn} < count))
    else $error("pending nearest node beyond tree");

endmodule

@@ tb/tb_rrt_star_tree_extension.sv @@
// Self-checking testbench for the RRT* tree extension engine.
`timescale 1ns / 100ps

module tb_rrt_star_tree_extension;
  import rrt_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  // Expected result of one command
  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic [IDW-1:0]       id, par;
    logic [COSTW-1:0]     cost;
    logic                 goal;
    logic [IDW-1:0]       gnode;
    status_t              st;
  } outcome_t;

  // One command transaction
  typedef struct {
    cmd_t                 op;
    logic signed [CW-1:0] sx, sy, sz;
    logic                 clear;
    logic [IDW-1:0]       idx;
    bit                   typed;
    outcome_t             want;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] cmd = CMD_RESTART;
  logic signed [CW-1:0] sample_x = '0, sample_y = '0, sample_z = '0;
  logic collision_free = 1'b0;
  logic [IDW-1:0] node_index = '0;
  logic signed [CW-1:0] point_x, point_y, point_z;
  logic [IDW-1:0] node_id, parent_id, goal_node;
  logic [COSTW-1:0] path_cost;
  logic goal_reached;
  logic [2:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFGW-1:0] cfg_index = REG_STEP;
  logic [CW-1:0] cfg_data = '0;

  rrt_star_tree_extension u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .cmd(cmd),
    .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
    .collision_free(collision_free), .node_index(node_index),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .node_id(node_id), .parent_id(parent_id), .path_cost(path_cost),
    .goal_reached(goal_reached), .goal_node(goal_node), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Tree model state and register copy
  longint unsigned lim_step, lim_radius;
  longint goal_pt[3], start_pt[3];
  longint tx[MAX_NODES], ty[MAX_NODES], tz[MAX_NODES];
  int tpar[MAX_NODES];
  longint unsigned tcost[MAX_NODES];
  int tree_n;
  bit pend_ok;
  longint pend_x, pend_y, pend_z;
  int pend_near;
  bit goal_hit;
  int goal_at;

  outcome_t outcome_q[$];
  command_t directed_q[$];
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  int n_op[4] = '{0, 0, 0, 0};
  int n_status[5] = '{0, 0, 0, 0, 0};
  int idle_cycles = 0;

  function automatic longint unsigned gap_sq(longint ax, longint ay, longint az,
                                             longint bx, longint by, longint bz);
    longint unsigned dx, dy, dz;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    dz = (az >= bz) ? az - bz : bz - az;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned add_sat(longint unsigned c, longint unsigned d);
    longint unsigned s;
    s = c + d;
    return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Move from base toward target by step * d / norm, rounded half away from zero
  function automatic longint steer(longint base, longint tgt, longint unsigned norm);
    longint unsigned mag, q;
    longint off;
    mag = (tgt >= base) ? tgt - base : base - tgt;
    q = (lim_step * mag + norm / 2) / norm;
    off = q;
    return clamp_coord((tgt >= base) ? base + off : base - off);
  endfunction

  function automatic longint unsigned node_dist(int i, longint x, longint y, longint z);
    return root_floor(gap_sq(tx[i], ty[i], tz[i], x, y, z));
  endfunction

  function automatic outcome_t pack_out(longint x, longint y, longint z, int id, int par,
                                        longint unsigned cost, status_t st);
    outcome_t o;
    o.x = CW'(x); o.y = CW'(y); o.z = CW'(z);
    o.id = IDW'(id); o.par = IDW'(par); o.cost = COSTW'(cost);
    o.goal = goal_hit; o.gnode = IDW'(goal_at); o.st = st;
    return o;
  endfunction

  function automatic outcome_t fixed(int x, int y, int z, int id, int par, longint cost,
                                     bit goal, int gnode, status_t st);
    outcome_t o;
    o.x = CW'(x); o.y = CW'(y); o.z = CW'(z);
    o.id = IDW'(id); o.par = IDW'(par); o.cost = COSTW'(cost);
    o.goal = goal; o.gnode = IDW'(gnode); o.st = st;
    return o;
  endfunction

  task automatic tree_restart();
    tx[0] = start_pt[0]; ty[0] = start_pt[1]; tz[0] = start_pt[2];
    tpar[0] = 0; tcost[0] = 0;
    tree_n = 1;
    pend_ok = 0;
    pend_x = 0; pend_y = 0; pend_z = 0;
    pend_near = 0;
    goal_hit = 0;
    goal_at = 0;
  endtask

  // Advance the tree model by one command and return its result
  task automatic plan_step(input command_t c, output outcome_t o);
    longint sx, sy, sz, nx, ny, nz;
    longint unsigned bd, d, r2, cst, cand;
    int best, par, nn;
    sx = c.sx; sy = c.sy; sz = c.sz;
    case (c.op)
      CMD_RESTART: begin
        tree_restart();
        o = pack_out(tx[0], ty[0], tz[0], 0, 0, 0, ST_OK);
      end
      CMD_PROPOSE: begin
        best = 0;
        bd = gap_sq(tx[0], ty[0], tz[0], sx, sy, sz);
        for (int i = 1; i < tree_n; i++) begin
          d = gap_sq(tx[i], ty[i], tz[i], sx, sy, sz);
          if (d < bd) begin
            bd = d;
            best = i;
          end
        end
        if (bd > lim_step * lim_step) begin
          d = root_floor(bd);
          nx = steer(tx[best], sx, d);
          ny = steer(ty[best], sy, d);
          nz = steer(tz[best], sz, d);
        end else begin
          nx = sx; ny = sy; nz = sz;
        end
        cst = add_sat(tcost[best], node_dist(best, nx, ny, nz));
        if (tree_n >= MAX_NODES) begin
          pend_ok = 0;
          o = pack_out(nx, ny, nz, 0, best, cst, ST_FULL);
        end else begin
          pend_ok = 1;
          pend_x = nx; pend_y = ny; pend_z = nz;
          pend_near = best;
          o = pack_out(nx, ny, nz, 0, best, cst, ST_OK);
        end
      end
      CMD_COMMIT: begin
        if (!pend_ok) begin
          o = pack_out(0, 0, 0, 0, 0, 0, ST_NO_PEND);
        end else if (tree_n >= MAX_NODES) begin
          pend_ok = 0;
          o = pack_out(pend_x, pend_y, pend_z, 0, pend_near, 0, ST_FULL);
        end else if (!c.clear) begin
          pend_ok = 0;
          o = pack_out(pend_x, pend_y, pend_z, 0, pend_near, 0, ST_COLLIDE);
        end else begin
          pend_ok = 0;
          nn = tree_n;
          r2 = lim_radius * lim_radius;
          par = pend_near;
          cst = add_sat(tcost[par], node_dist(par, pend_x, pend_y, pend_z));
          // cheapest parent in the neighborhood
          for (int k = 0; k < nn; k++) begin
            if (gap_sq(tx[k], ty[k], tz[k], pend_x, pend_y, pend_z) < r2) begin
              cand = add_sat(tcost[k], node_dist(k, pend_x, pend_y, pend_z));
              if (cand < cst) begin
                cst = cand;
                par = k;
              end
            end
          end
          tx[nn] = pend_x; ty[nn] = pend_y; tz[nn] = pend_z;
          tpar[nn] = par; tcost[nn] = cst;
          // rewire neighbors that get cheaper through the new node
          for (int k = 0; k < nn; k++) begin
            if (gap_sq(tx[k], ty[k], tz[k], pend_x, pend_y, pend_z) < r2) begin
              cand = add_sat(cst, node_dist(k, pend_x, pend_y, pend_z));
              if (cand < tcost[k]) begin
                tcost[k] = cand;
                tpar[k] = nn;
              end
            end
          end
          tree_n = nn + 1;
          if (gap_sq(pend_x, pend_y, pend_z, goal_pt[0], goal_pt[1], goal_pt[2])
              <= lim_step * lim_step) begin
            goal_hit = 1;
            goal_at = nn;
          end
          o = pack_out(pend_x, pend_y, pend_z, nn, par, cst, ST_OK);
        end
      end
      default: begin
        if (c.idx >= tree_n)
          o = pack_out(0, 0, 0, 0, 0, 0, ST_BAD_INDEX);
        else
          o = pack_out(tx[c.idx], ty[c.idx], tz[c.idx], c.idx, tpar[c.idx],
                       tcost[c.idx], ST_OK);
      end
    endcase
  endtask

  // Register write over the configuration channel
  task automatic write_reg(reg_idx_t r, longint v);
    repeat ($urandom_range(0, 14)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v[CW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (r)
      REG_STEP:    lim_step = v & 23'h7FFFFF;
      REG_RADIUS:  lim_radius = v & 23'h7FFFFF;
      REG_GOAL_X:  goal_pt[0] = v;
      REG_GOAL_Y:  goal_pt[1] = v;
      REG_GOAL_Z:  goal_pt[2] = v;
      REG_START_X: start_pt[0] = v;
      REG_START_Y: start_pt[1] = v;
      default:     start_pt[2] = v;
    endcase
  endtask

  task automatic write_all(longint st, longint rad, longint g0, longint g1, longint g2,
                           longint s0, longint s1, longint s2);
    write_reg(REG_STEP, st);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_GOAL_X, g0);
    write_reg(REG_GOAL_Y, g1);
    write_reg(REG_GOAL_Z, g2);
    write_reg(REG_START_X, s0);
    write_reg(REG_START_Y, s1);
    write_reg(REG_START_Z, s2);
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain();
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Append one row to the directed table
  function automatic void add_row(command_t c);
    directed_q.insert(directed_q.size(), c);
  endfunction

  // Issue one command transaction, then record what it should return
  task automatic issue(command_t c);
    outcome_t o;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c.op;
    sample_x <= c.sx; sample_y <= c.sy; sample_z <= c.sz;
    collision_free <= c.clear;
    node_index <= c.idx;
    do @(posedge clk); while (busy);
    plan_step(c, o);
    outcome_q.insert(outcome_q.size(), c.typed ? c.want : o);
    n_items++;
    n_op[c.op]++;
  endtask

  function automatic command_t mk_cmd(cmd_t op, int sx, int sy, int sz, bit clr, int idx);
    command_t c;
    c.op = op;
    c.sx = CW'(sx); c.sy = CW'(sy); c.sz = CW'(sz);
    c.clear = clr;
    c.idx = IDW'(idx);
    c.typed = 0;
    return c;
  endfunction

  function automatic command_t mk_typed(cmd_t op, int idx, outcome_t w);
    command_t c;
    c = mk_cmd(op, 0, 0, 0, 0, idx);
    c.typed = 1;
    c.want = w;
    return c;
  endfunction

  // Random coordinate: mostly near the current tree, sometimes anywhere
  function automatic logic signed [CW-1:0] pick_coord(longint base);
    longint span;
    if ($urandom_range(0, 6) == 0) return CW'($urandom);
    span = lim_step * 3 + 64;
    if (span > 64'd2000000) span = 2000000;
    return CW'(clamp_coord(base + longint'($urandom_range(0, 32'(2 * span))) - span));
  endfunction

  function automatic command_t rand_propose();
    int k;
    k = $urandom_range(0, tree_n - 1);
    return mk_cmd(CMD_PROPOSE, pick_coord(tx[k]), pick_coord(ty[k]), pick_coord(tz[k]),
                  1'($urandom), $urandom);
  endfunction

  // Random mix: mostly propose then commit, plus reads, restarts and stray commands
  task automatic random_phase(int count);
    command_t c;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        issue(mk_cmd(CMD_RESTART, $urandom, $urandom, $urandom, 1'($urandom), $urandom));
      end else if (r < 16) begin
        c = mk_cmd(CMD_READ, $urandom, $urandom, $urandom, 1'($urandom), $urandom);
        if ($urandom_range(0, 1)) c.idx = IDW'($urandom_range(0, tree_n + 1));
        issue(c);
      end else if (r < 20) begin
        issue(mk_cmd(CMD_COMMIT, $urandom, $urandom, $urandom, 1'b1, $urandom));
      end else if (r < 24) begin
        issue(rand_propose());
      end else begin
        issue(rand_propose());
        c = mk_cmd(CMD_COMMIT, $urandom, $urandom, $urandom,
                   $urandom_range(0, 9) != 0, $urandom);
        issue(c);
        n++;
      end
    end
  endtask

  // Result checker
  task automatic check_result();
    outcome_t e;
    bit bad;
    n_results++;
    if (outcome_q.size() == 0) begin
      $display("%0t: unexpected result, status %0d node %0d", $time, status, node_id);
      errors++;
    end else begin
      e = outcome_q.pop_front();
      bad = (point_x !== e.x) || (point_y !== e.y) || (point_z !== e.z) ||
            (node_id !== e.id) || (parent_id !== e.par) || (path_cost !== e.cost) ||
            (goal_reached !== e.goal) || (goal_node !== e.gnode) || (status !== e.st);
      if (bad) begin
        $display("%0t: mismatch expected pt=(%0d,%0d,%0d) id=%0d par=%0d cost=%0d goal=%0b/%0d st=%0d",
                 $time, e.x, e.y, e.z, e.id, e.par, e.cost, e.goal, e.gnode, e.st);
        $display("%0t:          actual   pt=(%0d,%0d,%0d) id=%0d par=%0d cost=%0d goal=%0b/%0d st=%0d",
                 $time, point_x, point_y, point_z, node_id, parent_id, path_cost,
                 goal_reached, goal_node, status);
        errors++;
      end
      if (e.st <= ST_BAD_INDEX) n_status[e.st]++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) check_result();
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, outcome_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    lim_step = 4096;
    lim_radius = 8192;
    goal_pt = '{0, 0, 0};
    start_pt = '{0, 0, 0};
    tree_restart();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, root at the origin and goal three steps out on x
    write_all(4096, 8192, 12288, 0, 0, 0, 0, 0);
    add_row(mk_typed(CMD_READ, 0, fixed(0, 0, 0, 0, 0, 0, 0, 0, ST_OK)));
    add_row(mk_typed(CMD_COMMIT, 0, fixed(0, 0, 0, 0, 0, 0, 0, 0, ST_NO_PEND)));
    add_row(mk_typed(CMD_READ, 1023, fixed(0, 0, 0, 0, 0, 0, 0, 0, ST_BAD_INDEX)));
    add_row(mk_typed(CMD_READ, 1, fixed(0, 0, 0, 0, 0, 0, 0, 0, ST_BAD_INDEX)));
    add_row(mk_cmd(CMD_PROPOSE, 1000, 0, 0, 0, 0));
    add_row(mk_cmd(CMD_COMMIT, 0, 0, 0, 1, 0));
    add_row(mk_cmd(CMD_PROPOSE, 20000, 0, 0, 0, 0));
    add_row(mk_cmd(CMD_COMMIT, 0, 0, 0, 0, 0));
    add_row(mk_typed(CMD_COMMIT, 0, fixed(0, 0, 0, 0, 0, 0, 0, 0, ST_NO_PEND)));
    add_row(mk_cmd(CMD_PROPOSE, 8388607, 8388607, 8388607, 1, 1023));
    add_row(mk_cmd(CMD_COMMIT, 0, 0, 0, 1, 0));
    add_row(mk_cmd(CMD_PROPOSE, -8388608, -8388608, -8388608, 0, 0));
    add_row(mk_cmd(CMD_COMMIT, -1, -1, -1, 1, 1023));
    // equidistant from root and node 1: lowest index wins
    add_row(mk_cmd(CMD_PROPOSE, 500, 0, 0, 0, 0));
    add_row(mk_cmd(CMD_COMMIT, 0, 0, 0, 1, 0));
    // a second proposal toward the goal replaces the first before the commit
    add_row(mk_cmd(CMD_PROPOSE, 12000, 100, 0, 0, 0));
    add_row(mk_cmd(CMD_PROPOSE, 11000, 100, -50, 0, 0));
    add_row(mk_cmd(CMD_COMMIT, 0, 0, 0, 1, 0));
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 1));
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 5));
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 6));
    add_row(mk_cmd(CMD_PROPOSE, 3000, 3000, 3000, 0, 0));
    add_row(mk_typed(CMD_RESTART, 0, fixed(0, 0, 0, 0, 0, 0, 0, 0, ST_OK)));
    add_row(mk_typed(CMD_COMMIT, 0, fixed(0, 0, 0, 0, 0, 0, 0, 0, ST_NO_PEND)));
    add_row(mk_typed(CMD_READ, 1, fixed(0, 0, 0, 0, 0, 0, 0, 0, ST_BAD_INDEX)));
    foreach (directed_q[i]) issue(directed_q[i]);
    start <= 1'b0;
    drain();

    // Moderate random settings
    write_all($urandom_range(1000, 8000), $urandom_range(2000, 20000),
              longint'($urandom_range(0, 40000)) - 20000, $urandom_range(0, 9000),
              -longint'($urandom_range(0, 9000)), longint'($urandom_range(0, 16000)) - 8000,
              $urandom_range(0, 8000), -longint'($urandom_range(0, 8000)));
    issue(mk_cmd(CMD_RESTART, 0, 0, 0, 0, 0));
    random_phase(50);
    start <= 1'b0;
    drain();

    // Largest step and radius, corners of the coordinate range
    write_all(8388607, 8388607, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
    issue(mk_cmd(CMD_RESTART, 0, 0, 0, 0, 0));
    random_phase(35);
    start <= 1'b0;
    drain();

    // Zero step and radius
    write_all(0, 0, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
    issue(mk_cmd(CMD_RESTART, 0, 0, 0, 0, 0));
    random_phase(35);
    start <= 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d commands (restart %0d, propose %0d, commit %0d, read %0d) in 4 settings.",
             n_items, n_op[0], n_op[1], n_op[2], n_op[3]);
    $display("Checked %0d results: ok %0d, no proposal %0d, collision %0d, bad index %0d.",
             n_results, n_status[0], n_status[1], n_status[3], n_status[4]);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
